>>> rtl/core/cpfl_pkg.sv
package cpfl_pkg;

    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] TOTAL_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] DANGER_RST = 11'd972;
    localparam logic [CFG_W-1:0] SAFE_RST   = 11'd921;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOTAL  = 2'd0,
        REG_DANGER = 2'd1,
        REG_SAFE   = 2'd2
    } cfg_reg_t;

endpackage

>>> rtl/core/cpfl_run_store.sv
module cpfl_run_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_run,
    input  logic [DW-1:0] wr_link,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_run,
    output logic [DW-1:0] rd_link
);

    logic [2*DW-1:0] mem [DEPTH];
    logic [2*DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_run, wr_link};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_run  = rd_data_reg[2*DW-1:DW];
    assign rd_link = rd_data_reg[DW-1:0];

endmodule

>>> rtl/core/chunk_pool_free_list_allocator.sv
// Fixed-size chunk pool allocator with a run-length free list.
// Input channel (s_valid/s_ready): s_op selects allocate or free; s_freed_index
// names the chunk returned by a free. Each request yields exactly one result on
// the m_ channel: status, granted chunk, free count, danger excess and the
// over-safeline flag, all as they stand after that request.
// A request passes through two registers before its result shows on m_valid:
// one input register, one result register.
// Throughput is one request per cycle while m_ready is high. The run after the
// current head is held in a look-ahead register; when an allocate exhausts the
// head run, the store read for the following run is issued at once and its
// registered output is forwarded into the next request's logic.
// Configuration writes (cfg_we) take effect at once; writing total_chunks
// resets the pool to one run covering every chunk.
// Reset (aresetn low, synchronous) empties both registers and leaves the pool
// as one full run with default levels. When the receiver holds m_ready low,
// the result stays put, the input register still takes one more request, and
// s_ready then drops until the result is taken.
module chunk_pool_free_list_allocator #(
    parameter int POOL_CHUNKS = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpfl_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [cpfl_pkg::IDX_W-1:0]          s_freed_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cpfl_pkg::status_t                   m_status,
    output logic [cpfl_pkg::IDX_W-1:0]          m_granted_index,
    output logic [cpfl_pkg::CFG_W-1:0]          m_free_count,
    output logic [cpfl_pkg::CFG_W-1:0]          m_danger_excess,
    output logic                                m_over_safeline
);
    import cpfl_pkg::*;

    localparam int CW = $clog2(POOL_CHUNKS + 1);
    localparam int AW = $clog2(POOL_CHUNKS);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] NULL_LINK = CW'(POOL_CHUNKS);
    localparam logic [XW-1:0] POOL_X = XW'(POOL_CHUNKS);

    function automatic logic [XW-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        if (t == '0) begin
            t = XW'(1);
        end else if (t > POOL_X) begin
            t = POOL_X;
        end
        return t;
    endfunction

    logic [CFG_W-1:0] total_reg, total_next;
    logic [CFG_W-1:0] danger_reg, danger_next;
    logic [CFG_W-1:0] safe_reg, safe_next;

    logic [CW-1:0] head_index_reg, head_index_next;
    logic [CW-1:0] head_run_reg, head_run_next;
    logic [CW-1:0] head_next_reg, head_next_next;
    logic [CW-1:0] free_total_reg, free_total_next;
    logic [CW-1:0] cache_run_reg, cache_run_next;
    logic [CW-1:0] cache_link_reg, cache_link_next;
    logic          rd_pend_reg, rd_pend_next;

    logic             in_valid_reg;
    op_t              in_op_reg;
    logic [IDX_W-1:0] in_idx_reg;

    logic             out_valid_reg;
    status_t          out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_granted_reg, out_granted_next;
    logic [CFG_W-1:0] out_free_reg, out_free_next;
    logic [CFG_W-1:0] out_excess_reg, out_excess_next;
    logic             out_over_reg, out_over_next;

    logic          proc;
    logic [XW-1:0] pool_size_x;
    logic [XW-1:0] cfg_size_x;
    logic [CW-1:0] cache_run_eff, cache_link_eff;
    logic [CW-1:0] rd_run, rd_link;
    logic          wr_en, rd_en;
    logic [CW-1:0] link;
    logic [XW-1:0] idx_x, free_x, used_x, danger_x, safe_x;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    assign pool_size_x = clamp_size(total_reg);
    assign cfg_size_x  = clamp_size(cfg_wdata);

    assign cache_run_eff  = rd_pend_reg ? rd_run  : cache_run_reg;
    assign cache_link_eff = rd_pend_reg ? rd_link : cache_link_reg;

    cpfl_run_store #(
        .DEPTH (POOL_CHUNKS),
        .AW    (AW),
        .DW    (CW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (head_index_reg[AW-1:0]),
        .wr_run  (head_run_reg),
        .wr_link (head_next_reg),
        .rd_en   (rd_en),
        .rd_addr (cache_link_eff[AW-1:0]),
        .rd_run  (rd_run),
        .rd_link (rd_link)
    );

    always_comb begin
        head_index_next  = head_index_reg;
        head_run_next    = head_run_reg;
        head_next_next   = head_next_reg;
        free_total_next  = free_total_reg;
        cache_run_next   = cache_run_eff;
        cache_link_next  = cache_link_eff;
        rd_pend_next     = 1'b0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        link             = NULL_LINK;
        out_status_next  = ST_OK;
        out_granted_next = '0;
        idx_x            = XW'(in_idx_reg);

        if (proc) begin
            if (in_op_reg == OP_ALLOC) begin
                if (free_total_reg == '0) begin
                    out_status_next = ST_EMPTY;
                end else begin
                    out_granted_next = IDX_W'(head_index_reg);
                    free_total_next  = free_total_reg - CW'(1);
                    if (head_run_reg > CW'(1)) begin
                        head_run_next   = head_run_reg - CW'(1);
                        head_index_next = head_index_reg + CW'(1);
                    end else if (head_next_reg < NULL_LINK) begin
                        // pop: look-ahead run becomes head, refill from store
                        head_index_next = head_next_reg;
                        head_run_next   = cache_run_eff;
                        head_next_next  = cache_link_eff;
                        rd_en           = 1'b1;
                        rd_pend_next    = 1'b1;
                    end else begin
                        head_index_next = NULL_LINK;
                        head_run_next   = '0;
                        head_next_next  = NULL_LINK;
                    end
                end
            end else begin
                if (idx_x >= pool_size_x || XW'(free_total_reg) >= pool_size_x) begin
                    out_status_next = ST_RANGE;
                end else begin
                    if (free_total_reg != '0 && head_index_reg < NULL_LINK) begin
                        wr_en           = 1'b1;
                        link            = head_index_reg;
                        cache_run_next  = head_run_reg;
                        cache_link_next = head_next_reg;
                    end
                    head_index_next = idx_x[CW-1:0];
                    head_run_next   = CW'(1);
                    head_next_next  = link;
                    free_total_next = free_total_reg + CW'(1);
                end
            end
        end

        free_x   = XW'(free_total_next);
        used_x   = (free_x <= pool_size_x) ? (pool_size_x - free_x) : '0;
        danger_x = XW'(danger_reg);
        safe_x   = XW'(safe_reg);
        out_free_next   = free_x[CFG_W-1:0];
        out_over_next   = used_x > safe_x;
        out_excess_next = '0;
        if (used_x > danger_x && used_x > safe_x) begin
            out_excess_next = CFG_W'(used_x - safe_x);
        end
    end

    always_comb begin
        total_next  = total_reg;
        danger_next = danger_reg;
        safe_next   = safe_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TOTAL:  total_next  = cfg_wdata;
                REG_DANGER: danger_next = cfg_wdata;
                REG_SAFE:   safe_next   = cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= TOTAL_RST;
            danger_reg     <= DANGER_RST;
            safe_reg       <= SAFE_RST;
            head_index_reg <= '0;
            head_run_reg   <= CW'(clamp_size(TOTAL_RST));
            head_next_reg  <= NULL_LINK;
            free_total_reg <= CW'(clamp_size(TOTAL_RST));
            rd_pend_reg    <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            total_reg  <= total_next;
            danger_reg <= danger_next;
            safe_reg   <= safe_next;
            if (cfg_we && cfg_index == REG_TOTAL) begin
                head_index_reg <= '0;
                head_run_reg   <= cfg_size_x[CW-1:0];
                head_next_reg  <= NULL_LINK;
                free_total_reg <= cfg_size_x[CW-1:0];
                rd_pend_reg    <= 1'b0;
            end else begin
                head_index_reg <= head_index_next;
                head_run_reg   <= head_run_next;
                head_next_reg  <= head_next_next;
                free_total_reg <= free_total_next;
                rd_pend_reg    <= rd_pend_next;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cache_run_reg  <= cache_run_next;
        cache_link_reg <= cache_link_next;
        if (s_ready && s_valid) begin
            in_op_reg  <= op_t'(s_op);
            in_idx_reg <= s_freed_index;
        end
        if (proc) begin
            out_status_reg  <= out_status_next;
            out_granted_reg <= out_granted_next;
            out_free_reg    <= out_free_next;
            out_excess_reg  <= out_excess_next;
            out_over_reg    <= out_over_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_granted_index = out_granted_reg;
    assign m_free_count    = out_free_reg;
    assign m_danger_excess = out_excess_reg;
    assign m_over_safeline = out_over_reg;

`ifndef ASSERT_OFF
    a_free_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(free_total_reg) <= pool_size_x)
        else $error("free count above pool size");

    a_empty_run_null: assert property (@(posedge aclk) disable iff (!aresetn)
        head_run_reg == '0 |-> head_index_reg == NULL_LINK)
        else $error("empty head run on a live head");

    a_pend_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(proc && in_op_reg == OP_ALLOC))
        else $error("store read pending without a pop");

    a_grant_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_granted_index == '0)
        else $error("grant reported on a failed request");
`endif

endmodule

>>> test/chunk_pool_monitor.sv
module chunk_pool_monitor #(
    parameter int POOL_CHUNKS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cpfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpfl_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_op,
    input  logic [cpfl_pkg::IDX_W-1:0]        s_freed_index,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  cpfl_pkg::status_t                 m_status,
    input  logic [cpfl_pkg::IDX_W-1:0]        m_granted_index,
    input  logic [cpfl_pkg::CFG_W-1:0]        m_free_count,
    input  logic [cpfl_pkg::CFG_W-1:0]        m_danger_excess,
    input  logic                              m_over_safeline,
    output int                                fail_count,
    output int                                pending,
    output int                                checked,
    output int                                empties,
    output int                                refusals
);
    import cpfl_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   grant;
        logic [CFG_W-1:0]   free_cnt;
        logic [CFG_W-1:0]   excess;
        logic               over;
    } pool_result_t;

    localparam logic [CFG_W-1:0] NULL_LINK = CFG_W'(POOL_CHUNKS);

    logic [CFG_W-1:0] total_reg, danger_reg, safe_reg;
    logic [CFG_W-1:0] head_chunk, head_len, head_link, free_cnt;
    logic [CFG_W-1:0] len_mem  [POOL_CHUNKS];
    logic [CFG_W-1:0] link_mem [POOL_CHUNKS];

    pool_result_t expected_results[$];
    int errors    = 0;
    int n_checked = 0;
    int n_empty   = 0;
    int n_refused = 0;

    assign fail_count = errors;
    assign checked    = n_checked;
    assign empties    = n_empty;
    assign refusals   = n_refused;

    function automatic int unsigned pool_cap();
        int unsigned t;
        t = total_reg;
        if (t == 0) t = 1;
        if (t > POOL_CHUNKS) t = POOL_CHUNKS;
        return t;
    endfunction

    function automatic void pool_reinit();
        head_chunk = '0;
        head_len   = CFG_W'(pool_cap());
        head_link  = NULL_LINK;
        free_cnt   = CFG_W'(pool_cap());
    endfunction

    function automatic pool_result_t pool_step(input op_t op, input logic [IDX_W-1:0] idx);
        pool_result_t r;
        int unsigned cap, used, nxt;
        logic [CFG_W-1:0] link;
        cap = pool_cap();
        r = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (free_cnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.grant  = head_chunk[IDX_W-1:0];
                free_cnt = free_cnt - 1'b1;
                if (head_len > 1) begin
                    head_len   = head_len - 1'b1;
                    head_chunk = head_chunk + 1'b1;
                end else if (head_link < NULL_LINK) begin
                    nxt        = head_link;
                    head_chunk = head_link;
                    head_len   = len_mem[nxt];
                    head_link  = link_mem[nxt];
                end else begin
                    head_chunk = NULL_LINK;
                    head_len   = '0;
                    head_link  = NULL_LINK;
                end
            end
        end else if (idx >= cap || free_cnt >= cap) begin
            r.status = ST_RANGE;
        end else begin
            link = NULL_LINK;
            if (free_cnt != 0 && head_chunk < NULL_LINK) begin
                len_mem[head_chunk]  = head_len;
                link_mem[head_chunk] = head_link;
                link = head_chunk;
            end
            head_chunk = CFG_W'(idx);
            head_len   = CFG_W'(1);
            head_link  = link;
            free_cnt   = free_cnt + 1'b1;
        end
        used = (free_cnt <= cap) ? cap - free_cnt : 0;
        r.free_cnt = free_cnt;
        if (used > danger_reg && used > safe_reg) r.excess = CFG_W'(used - safe_reg);
        r.over = (used > safe_reg);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40) $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result();
        pool_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no request outstanding, status %0d",
                                      m_status));
            return;
        end
        want = expected_results.pop_front();
        n_checked++;
        if (m_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
        if (m_granted_index !== want.grant)
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      m_granted_index, want.grant));
        if (m_free_count !== want.free_cnt)
            report_mismatch($sformatf("free_count %0d, want %0d",
                                      m_free_count, want.free_cnt));
        if (m_danger_excess !== want.excess)
            report_mismatch($sformatf("danger_excess %0d, want %0d",
                                      m_danger_excess, want.excess));
        if (m_over_safeline !== want.over)
            report_mismatch($sformatf("over_safeline %0d, want %0d",
                                      m_over_safeline, want.over));
        if (want.status == ST_EMPTY) n_empty++;
        if (want.status == ST_RANGE) n_refused++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  = TOTAL_RST;
            danger_reg = DANGER_RST;
            safe_reg   = SAFE_RST;
            foreach (len_mem[i]) begin
                len_mem[i]  = '0;
                link_mem[i] = '0;
            end
            pool_reinit();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_TOTAL: begin
                        total_reg = cfg_wdata;
                        pool_reinit();
                    end
                    REG_DANGER: danger_reg = cfg_wdata;
                    REG_SAFE:   safe_reg   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(pool_step(op_t'(s_op), s_freed_index));
        end
        pending <= expected_results.size();
    end

endmodule

>>> test/chunk_pool_free_list_allocator_tb.sv
module chunk_pool_free_list_allocator_tb;
    import cpfl_pkg::*;

    localparam int POOL_CHUNKS = 1024;

    typedef enum {NO_PRESSURE, RX_HOLD, TX_DRAIN} pressure_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    logic [IDX_W-1:0]       s_freed_index;
    logic                   m_valid;
    logic                   m_ready;
    status_t                m_status;
    logic [IDX_W-1:0]       m_granted_index;
    logic [CFG_W-1:0]       m_free_count;
    logic [CFG_W-1:0]       m_danger_excess;
    logic                   m_over_safeline;

    int fail_count, pending, checked, empties, refusals;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    bit rx_hold_go     = 1'b0;
    int requests_sent  = 0;
    int random_sent    = 0;
    int settings_used  = 0;

    chunk_pool_free_list_allocator #(.POOL_CHUNKS(POOL_CHUNKS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_freed_index(s_freed_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_index(m_granted_index), .m_free_count(m_free_count),
        .m_danger_excess(m_danger_excess), .m_over_safeline(m_over_safeline)
    );

    chunk_pool_monitor #(.POOL_CHUNKS(POOL_CHUNKS)) pool_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_freed_index(s_freed_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_granted_index(m_granted_index), .m_free_count(m_free_count),
        .m_danger_excess(m_danger_excess), .m_over_safeline(m_over_safeline),
        .fail_count(fail_count), .pending(pending), .checked(checked),
        .empties(empties), .refusals(refusals)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #800000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_go) begin
                rx_hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (64) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic push_request(input op_t op, input logic [IDX_W-1:0] idx);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_freed_index <= idx;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic configure(input int unsigned total, input int unsigned danger,
                             input int unsigned safe);
        wait_drained();
        write_reg(REG_TOTAL,  CFG_W'(total));
        write_reg(REG_DANGER, CFG_W'(danger));
        write_reg(REG_SAFE,   CFG_W'(safe));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int unsigned total, input int unsigned danger,
                             input int unsigned safe, input int count,
                             input pressure_t pressure);
        int unsigned cap, alloc_pct, burst_left;
        op_t op;
        logic [IDX_W-1:0] idx;
        configure(total, danger, safe);
        cap = (total == 0) ? 1 : ((total > POOL_CHUNKS) ? POOL_CHUNKS : total);
        alloc_pct = 50;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
            end
            if (random_sent < 640) begin
                tx_idle_pct = 6;
                rx_idle_pct = 80;
            end else if (random_sent < 1280) begin
                tx_idle_pct = 80;
                rx_idle_pct = 6;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == count / 2) begin
                if (pressure == RX_HOLD) begin
                    rx_hold_go = 1'b1;
                    burst_left = 40;
                end else if (pressure == TX_DRAIN) begin
                    wait_drained();
                end
            end
            if (burst_left != 0) begin
                tx_idle_pct = 0;
                burst_left--;
            end
            op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            idx = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, cap - 1))
                                                : IDX_W'($urandom);
            push_request(op, idx);
            random_sent++;
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_TOTAL;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_op          <= OP_ALLOC;
        s_freed_index <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset levels: frees into a full pool, pushes, pops back into the run
        push_request(OP_FREE, 10'd0);
        push_request(OP_FREE, 10'd1023);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd1023);
        push_request(OP_FREE, 10'd1);
        push_request(OP_FREE, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);

        // zero total acts as one chunk; null link pop and empty pool
        configure(0, 0, 0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_FREE, 10'd1023);
        push_request(OP_FREE, 10'd0);
        push_request(OP_FREE, 10'd0);

        // double free, free into a full pool
        configure(2, 2047, 2047);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_FREE, 10'd1);
        push_request(OP_FREE, 10'd1);
        push_request(OP_FREE, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);

        // oversize total clamps; safe line above danger line
        configure(2047, 1, 1024);
        push_request(OP_ALLOC, 10'd0);
        push_request(OP_ALLOC, 10'd0);

        run_phase(0,    0,    0,    80,  NO_PRESSURE);
        run_phase(1,    2047, 2047, 60,  NO_PRESSURE);
        run_phase(5,    3,    1,    250, NO_PRESSURE);
        run_phase(16,   12,   8,    350, RX_HOLD);
        run_phase(40,   30,   36,   350, TX_DRAIN);
        run_phase(9,    7,    4,    250, NO_PRESSURE);
        run_phase(2047, 20,   12,   200, NO_PRESSURE);
        run_phase(1024, 1024, 0,    150, NO_PRESSURE);
        run_phase(300,  0,    2047, 210, NO_PRESSURE);

        wait_drained();
        repeat (6) @(posedge aclk);

        $display("Sent %0d requests over %0d pool settings, pools of 1 to %0d chunks,",
                 requests_sent, settings_used, POOL_CHUNKS);
        $display("with stalls, a held receiver and a drain pause;");
        $display("%0d results, %0d empty, %0d refused.", checked, empties, refusals);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
